// ===== design/srk_pkg.sv =====
`default_nettype none
package srk_pkg;
  localparam int unsigned ValW = 32;
  localparam int unsigned IdxW = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_C = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_RD_C = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOWER = 3'd0,
    REG_TRANS = 3'd1,
    REG_ORDER = 3'd2,
    REG_DEPTH = 3'd3,
    REG_ALPHA = 3'd4,
    REG_BETA  = 3'd5
  } reg_e;

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic signed [ValW-1:0] element_value;
    logic [1:0] mode;
  } item_t;

  typedef struct packed {
    logic lower_triangle;
    logic transposed;
    logic [4:0] order;
    logic [4:0] depth;
    logic signed [ValW-1:0] alpha_gain;
    logic signed [ValW-1:0] beta_gain;
  } cfg_t;

  // 64-bit signed value saturated to 32 bits
  function automatic logic signed [ValW-1:0] sat32(input logic signed [63:0] x);
    logic signed [ValW-1:0] r;
    if (x > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = x[ValW-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/srk_stream_if.sv =====
`default_nettype none
interface srk_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [3:0] row;
  logic [3:0] col;
  logic signed [31:0] element_value;
  modport source(output valid, mode, row, col, element_value, input ready);
  modport sink(input valid, mode, row, col, element_value, output ready);
endinterface

interface srk_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] read_value;
  modport source(output valid, read_value, input ready);
  modport sink(input valid, read_value, output ready);
endinterface
`default_nettype wire

// ===== design/srk_mac.sv =====
`default_nettype none
// Dot-product accumulator and C update datapath: one product per cycle,
// registered after every multiply.
module srk_mac (
  input  wire logic clk_i,
  input  wire logic clear_i,
  input  wire logic acc_en_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] alpha_i,
  input  wire logic signed [31:0] beta_i,
  input  wire logic signed [31:0] c_i,
  input  wire logic fin_en_i,
  input  wire logic sum_en_i,
  output logic signed [31:0] result_o
);
  logic signed [63:0] prod_q, prod_d;
  logic signed [72:0] acc_q, acc_d;
  logic signed [63:0] t_q, b_q;
  logic signed [31:0] dsat;
  logic signed [56:0] accs;

  assign prod_d = x_i * y_i;
  assign accs = acc_q[72:16];
  always_comb begin
    if (accs > 57'sh7FFF_FFFF) dsat = 32'sh7FFF_FFFF;
    else if (accs < -57'sh8000_0000) dsat = 32'sh8000_0000;
    else dsat = accs[31:0];
  end
  assign acc_d = clear_i ? '0 : acc_q + 73'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (clear_i || acc_en_i) acc_q <= acc_d;
    if (fin_en_i) begin
      t_q <= (alpha_i * dsat) >>> 16;
      b_q <= (beta_i * c_i) >>> 16;
    end
    if (sum_en_i) result_o <= srk_pkg::sat32(t_q + b_q);
  end
endmodule
`default_nettype wire

// ===== design/symmetric_rank_k_update_unit.sv =====
`default_nettype none
// Loads take one word per cycle while in_if.ready is high. A read of C gives its
// result through the memory read register, then the output register, and holds off
// the input while the read is pending and while the result waits unaccepted.
// A run walks the n(n+1)/2 elements of one triangle of C; per element a clear, dot
// steps over k, a drain, then scale, sum and write-back. Order zero starts no run.
// rst_ni (async) clears control and config, sets gains 65536; A, C mems undefined.
module symmetric_rank_k_update_unit #(
  parameter int unsigned DIM_MAX = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srk_in_if.sink  in_if,
  srk_out_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int unsigned IW = $clog2(DIM_MAX);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned CW = $clog2(DIM_MAX + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DOT   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_WB    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  srk_pkg::cfg_t cfg_q;

  // memories, addressed by {row, col}
  logic signed [31:0] a_mem [2**AW];
  logic signed [31:0] c_mem [2**AW];
  logic signed [31:0] ax_q, ay_q, c_rd_q;

  logic [CW-1:0] n_w, k_w;
  logic [CW-1:0] i_q, j_q, l_q;
  logic [1:0] drain_q;
  logic out_valid_q;
  logic signed [31:0] out_data_q;
  logic signed [31:0] mac_res;
  logic rd_pend_q;

  assign n_w = (32'(cfg_q.order) > DIM_MAX) ? CW'(DIM_MAX) : CW'(cfg_q.order);
  assign k_w = (32'(cfg_q.depth) > DIM_MAX) ? CW'(DIM_MAX) : CW'(cfg_q.depth);

  // in-range check for parameters smaller than 16
  logic in_range;
  logic [AW-1:0] idx_in;
  assign in_range = (32'(in_if.row) < DIM_MAX) && (32'(in_if.col) < DIM_MAX);
  assign idx_in = {IW'(in_if.row), IW'(in_if.col)};

  // run addresses
  logic [IW-1:0] lx, ii, jj;
  logic [AW-1:0] ax_addr, ay_addr, c_addr;
  assign lx = l_q[IW-1:0];
  assign ii = i_q[IW-1:0];
  assign jj = j_q[IW-1:0];
  assign ax_addr = cfg_q.transposed ? {lx, ii} : {ii, lx};
  assign ay_addr = cfg_q.transposed ? {lx, jj} : {jj, lx};
  assign c_addr = {ii, jj};

  logic acc_fire;
  assign acc_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !(rd_pend_q || (out_valid_q && !out_if.ready));

  logic dot_step, acc_en_q, acc_en_qq;
  assign dot_step = (state_q == S_DOT) && (l_q < k_w);

  always_ff @(posedge clk_i) begin
    if (acc_fire && in_range && in_if.mode == srk_pkg::MODE_WR_A)
      a_mem[idx_in] <= in_if.element_value;
    if (acc_fire && in_range && in_if.mode == srk_pkg::MODE_WR_C)
      c_mem[idx_in] <= in_if.element_value;
    if (state_q == S_WB) c_mem[c_addr] <= mac_res;
    ax_q <= a_mem[ax_addr];
    ay_q <= a_mem[ay_addr];
    c_rd_q <= c_mem[(state_q == S_IDLE) ? idx_in : c_addr];
  end

  logic rd_in_q;
  always_ff @(posedge clk_i) rd_in_q <= in_range;

  srk_mac u_mac (
    .clk_i(clk_i),
    .clear_i(state_q == S_READ),
    .acc_en_i(acc_en_qq),
    .x_i(ax_q), .y_i(ay_q),
    .alpha_i(cfg_q.alpha_gain), .beta_i(cfg_q.beta_gain),
    .c_i(c_rd_q),
    .fin_en_i(state_q == S_FIN),
    .sum_en_i(state_q == S_SUM),
    .result_o(mac_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc_fire && in_if.mode == srk_pkg::MODE_RUN && n_w != '0) state_d = S_READ;
      S_READ:  state_d = S_DOT;
      S_DOT:   if (l_q >= k_w) state_d = S_DRAIN;
      S_DRAIN: if (drain_q == 2'd2) state_d = S_FIN;
      S_FIN:   state_d = S_SUM;
      S_SUM:   state_d = S_WB;
      S_WB: begin
        if (cfg_q.lower_triangle ? (i_q + 1'b1 == n_w && j_q + 1'b1 == n_w)
                                 : (i_q == j_q && j_q + 1'b1 == n_w)) state_d = S_IDLE;
        else state_d = S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q <= '{lower_triangle: 1'b0, transposed: 1'b0, order: '0, depth: '0,
                 alpha_gain: 32'sd65536, beta_gain: 32'sd65536};
      i_q <= '0; j_q <= '0; l_q <= '0; drain_q <= '0;
      out_valid_q <= 1'b0; rd_pend_q <= 1'b0;
      acc_en_q <= 1'b0; acc_en_qq <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_en_q <= dot_step;
      acc_en_qq <= acc_en_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srk_pkg::REG_LOWER: cfg_q.lower_triangle <= cfg_data_i[0];
          srk_pkg::REG_TRANS: cfg_q.transposed <= cfg_data_i[0];
          srk_pkg::REG_ORDER: cfg_q.order <= cfg_data_i[4:0];
          srk_pkg::REG_DEPTH: cfg_q.depth <= cfg_data_i[4:0];
          srk_pkg::REG_ALPHA: cfg_q.alpha_gain <= cfg_data_i;
          srk_pkg::REG_BETA:  cfg_q.beta_gain <= cfg_data_i;
          default: ;
        endcase
      end
      rd_pend_q <= acc_fire && in_if.mode == srk_pkg::MODE_RD_C;
      if (rd_pend_q) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      // element walk: column j outer, row i inner, within the triangle
      if (state_q == S_IDLE && state_d == S_READ) begin
        j_q <= '0;
        i_q <= '0;
        l_q <= '0;
      end
      if (state_q == S_READ) l_q <= '0;
      if (dot_step) l_q <= l_q + 1'b1;
      if (state_q == S_DOT && l_q >= k_w) drain_q <= '0;
      else if (state_q == S_DRAIN) drain_q <= drain_q + 1'b1;
      if (state_q == S_WB) begin
        if (cfg_q.lower_triangle) begin
          if (i_q + 1'b1 == n_w) begin
            j_q <= j_q + 1'b1;
            i_q <= j_q + 1'b1;
          end else i_q <= i_q + 1'b1;
        end else begin
          if (i_q == j_q) begin
            j_q <= j_q + 1'b1;
            i_q <= '0;
          end else i_q <= i_q + 1'b1;
        end
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) out_data_q <= rd_in_q ? c_rd_q : '0;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.read_value = out_data_q;

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("ready during run");
  a_rd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q) else $error("read lost");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (i_q < n_w && j_q < n_w)) else $error("index range");
  a_no_ovr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> out_valid_q) else $error("result dropped");
endmodule
`default_nettype wire
